>>> rtl/core/line_sensor_position_estimator_top_defines.svh
// ----------------------------------------------------------------------------
// Line sensor position estimator: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_POSITION_ESTIMATOR_TOP_DEFINES_SVH
`define LINE_SENSOR_POSITION_ESTIMATOR_TOP_DEFINES_SVH

// Same-cycle implication
`define LSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define LSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg
// Types, constants and the weight table of the line sensor position estimator.
// ----------------------------------------------------------------------------
package lsp_pkg;

	localparam int WINDOW_SIZE = 4;
	localparam int DIV_W       = 31;
	localparam int DIV_STEPS   = 31;
	localparam int DIVS_W      = 13;
	localparam int POS_W       = 25;
	localparam logic [32:0] POS_CLAMP = 33'd12288000;
	localparam logic [3:0]  WIN_CENTER = 4'd6;
	localparam logic [3:0]  WIN_LAST   = 4'd12;
	localparam logic [6:0]  LEVEL_MAX  = 7'd127;
	localparam logic [6:0]  THR_RESET  = 7'd64;

	localparam logic [1:0] SIDE_CENTER = 2'd0;
	localparam logic [1:0] SIDE_RIGHT  = 2'd1;
	localparam logic [1:0] SIDE_LEFT   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD,
		ST_NDIV,
		ST_MAC,
		ST_CHK,
		ST_CDIV,
		ST_OUT
	} lsp_state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DIVS_W-1:0] divisor;
	} lsp_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} lsp_div_rsp_t;

	// Sensor weights in units of 10 um, right side positive
	function automatic logic signed [15:0] lsp_weight(input logic [3:0] k);
		logic signed [15:0] w;
		case (k)
			4'd0:    w = 16'sd12000;
			4'd1:    w = 16'sd10400;
			4'd2:    w = 16'sd8800;
			4'd3:    w = 16'sd7200;
			4'd4:    w = 16'sd5550;
			4'd5:    w = 16'sd3950;
			4'd6:    w = 16'sd2350;
			4'd7:    w = 16'sd750;
			4'd8:    w = -16'sd750;
			4'd9:    w = -16'sd2350;
			4'd10:   w = -16'sd3950;
			4'd11:   w = -16'sd5550;
			4'd12:   w = -16'sd7200;
			4'd13:   w = -16'sd8800;
			4'd14:   w = -16'sd10400;
			4'd15:   w = -16'sd12000;
			default: w = 16'sd0;
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/line_sensor_position_estimator_top.sv
// ----------------------------------------------------------------------------
// line_sensor_position_estimator_top
// Sixteen-sensor line tracker: calibration, level normalization, activity
// bitmap and weighted centroid over a tracked four-sensor window.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Content
// s_axis    in   s_axis_tvalid/tready   one calibrate or sample item
// m_axis    out  m_axis_tvalid/tready   one position report per end of scan
// cfg       in   cfg_valid/cfg_ready    active_threshold write
//
// Steps: an item without end of scan is accepted and applied, and a sample
// that needs the shared 31-step restoring divider waits for its quotient.
// End of scan adds the window MAC over the four window sensors, a check,
// the centroid division and an output load; the division is skipped when
// the window sum is zero. Input is not ready until the item is done; a report
// still waiting at the output holds the output step and with it the input.
// Reset is asynchronous and clears all stores at once.
// ----------------------------------------------------------------------------
`include "line_sensor_position_estimator_top_defines.svh"

module line_sensor_position_estimator_top import lsp_pkg::*; #(
	parameter int NUM_SENSORS = 16,
	parameter int MIN_RANGE   = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [3:0] sensor_index, [15:4] sample_value, [27:16] cal_min, [39:28] cal_max
	input  logic [39:0] s_axis_tdata,
	// [0] action
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [24:0] position_q10, [28:25] offset_level, [30:29] side,
	// [46:31] active_bitmap, [47] zero
	output logic [47:0] m_axis_tdata,
	// [0] lost flag, window sum was zero
	output logic        m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	lsp_state_t st_q, st_d;

	logic [6:0]  thr_q;
	logic        act_q, eos_q;
	logic [3:0]  idx_q;
	logic [11:0] x_q, cmin_q, cmax_q;

	logic [6:0]  norm_q  [16];
	logic [11:0] min_q   [16];
	logic [12:0] range_q [16];
	logic [15:0] bitmap_q;
	logic [3:0]  ws_q;
	logic signed [POS_W-1:0] held_q;

	logic [1:0]  mac_q;
	logic signed [23:0] s_q;
	logic [8:0]  d_q;
	logic [3:0]  res_level_q;
	logic [1:0]  res_side_q;
	logic        res_lout_q;
	logic        m_valid_q;

	lsp_div_req_t div_req;
	lsp_div_rsp_t div_rsp;

	// Normalization bounds for the addressed sensor
	logic               idx_ok;
	logic [11:0]        mn;
	logic signed [13:0] rg;
	logic signed [14:0] mx;
	logic               above_max, below_min, bad_range, need_div;
	logic [11:0]        diff;
	logic [6:0]         fast_lvl;

	assign idx_ok    = {1'b0, idx_q} < 5'(NUM_SENSORS);
	assign mn        = min_q[idx_q];
	assign rg        = $signed({range_q[idx_q][12], range_q[idx_q]});
	assign mx        = $signed({3'b000, mn}) + 15'(rg);
	assign above_max = $signed({3'b000, x_q}) > mx;
	assign below_min = x_q < mn;
	assign bad_range = rg < $signed(14'(MIN_RANGE));
	assign need_div  = ~above_max & ~below_min & ~bad_range;
	assign diff      = x_q - mn;
	assign fast_lvl  = above_max ? LEVEL_MAX : 7'd0;

	// Level from the divider quotient: floor(q*127 / 2^17)
	logic [24:0] q127;
	logic [6:0]  div_lvl;
	assign q127    = {div_rsp.quot[17:0], 7'd0} - 25'(div_rsp.quot[17:0]);
	assign div_lvl = q127[23:17];

	// Window MAC operands
	logic [3:0]         mac_k;
	logic signed [23:0] mac_w;
	logic signed [23:0] mac_prod;
	assign mac_k    = ws_q + {2'b00, mac_q};
	assign mac_w    = 24'(lsp_weight(mac_k));
	assign mac_prod = mac_w * $signed({17'd0, norm_q[mac_k]});

	// Centroid magnitude, sign and clamp
	logic               s_neg;
	logic [23:0]        s_abs;
	logic [32:0]        mag_raw;
	logic [23:0]        mag;
	logic signed [POS_W-1:0] pos;
	logic signed [14:0] cur;
	assign s_neg   = s_q[23];
	assign s_abs   = s_neg ? 24'(-s_q) : 24'(s_q);
	assign mag_raw = {div_rsp.quot, 2'b00};
	assign mag     = (mag_raw > POS_CLAMP) ? POS_CLAMP[23:0] : mag_raw[23:0];
	assign pos     = s_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	assign cur     = pos[POS_W-1:10];

	// Offset level, side and next window from the integer position
	logic [3:0] lvl_c;
	logic [1:0] side_c;
	logic [3:0] ws_c;
	always_comb begin
		lvl_c  = 4'd0;
		side_c = SIDE_CENTER;
		ws_c   = WIN_CENTER;
		for (int i = 7; i >= 0; i--) begin
			if (16'(cur) > lsp_weight(4'(i))) begin
				lvl_c  = 4'(8 - i);
				side_c = SIDE_RIGHT;
				ws_c   = (lvl_c >= 4'd6) ? 4'd0 : WIN_CENTER - lvl_c;
			end else if (16'(cur) < lsp_weight(4'(15 - i))) begin
				lvl_c  = 4'(8 - i);
				side_c = SIDE_LEFT;
				ws_c   = (lvl_c >= 4'd6) ? WIN_LAST : WIN_CENTER + lvl_c;
			end
		end
	end

	// Next state and divider requests
	always_comb begin
		st_d             = st_q;
		div_req.start    = 1'b0;
		div_req.dividend = DIV_W'({diff, 17'd0});
		div_req.divisor  = rg[12:0];
		case (st_q)
			ST_IDLE: if (s_axis_tvalid) st_d = ST_UPD;
			ST_UPD: begin
				if (idx_ok && !act_q && need_div) begin
					div_req.start = 1'b1;
					st_d = ST_NDIV;
				end else begin
					st_d = eos_q ? ST_MAC : ST_IDLE;
				end
			end
			ST_NDIV: if (div_rsp.done) st_d = eos_q ? ST_MAC : ST_IDLE;
			ST_MAC: if (mac_q == 2'(WINDOW_SIZE - 1)) st_d = ST_CHK;
			ST_CHK: begin
				if (d_q == 9'd0) begin
					st_d = ST_OUT;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'({s_abs[22:0], 8'd0});
					div_req.divisor  = DIVS_W'(d_q);
					st_d = ST_CDIV;
				end
			end
			ST_CDIV: if (div_rsp.done) st_d = ST_OUT;
			ST_OUT: if (!m_valid_q || m_axis_tready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else         st_q <= st_d;
	end

	// Hold the accepted beat
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_axis_tvalid) begin
			act_q  <= s_axis_tuser;
			eos_q  <= s_axis_tlast;
			idx_q  <= s_axis_tdata[3:0];
			x_q    <= s_axis_tdata[15:4];
			cmin_q <= s_axis_tdata[27:16];
			cmax_q <= s_axis_tdata[39:28];
		end
	end

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        thr_q <= THR_RESET;
		else if (cfg_valid) thr_q <= cfg_data;
	end

	// Sensor stores and bitmap
	logic       lvl_we;
	logic [6:0] lvl_wd;
	assign lvl_we = (st_q == ST_UPD && idx_ok && !act_q && !need_div) ||
	                (st_q == ST_NDIV && div_rsp.done);
	assign lvl_wd = (st_q == ST_NDIV) ? div_lvl : fast_lvl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				norm_q[i]  <= '0;
				min_q[i]   <= '0;
				range_q[i] <= '0;
			end
			bitmap_q <= '0;
		end else begin
			if (st_q == ST_UPD && idx_ok && act_q) begin
				min_q[idx_q]   <= cmin_q;
				range_q[idx_q] <= 13'({1'b0, cmax_q} - {1'b0, cmin_q});
			end
			if (lvl_we) begin
				norm_q[idx_q]   <= lvl_wd;
				bitmap_q[idx_q] <= lvl_wd > thr_q;
			end
		end
	end

	// Window MAC accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_q <= '0;
		end else if (st_q == ST_MAC) begin
			mac_q <= mac_q + 1'b1;
		end else begin
			mac_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE) begin
			s_q <= '0;
			d_q <= '0;
		end else if (st_q == ST_MAC) begin
			s_q <= s_q + mac_prod;
			d_q <= d_q + {2'b00, norm_q[mac_k]};
		end
	end

	// Tracking state and the pending report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= WIN_CENTER;
			held_q      <= '0;
			res_level_q <= '0;
			res_side_q  <= SIDE_CENTER;
			res_lout_q  <= 1'b0;
		end else if (st_q == ST_CHK && d_q == 9'd0) begin
			res_level_q <= '0;
			res_side_q  <= SIDE_CENTER;
			res_lout_q  <= 1'b1;
		end else if (st_q == ST_CDIV && div_rsp.done) begin
			held_q      <= pos;
			ws_q        <= ws_c;
			res_level_q <= lvl_c;
			res_side_q  <= side_c;
			res_lout_q  <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (st_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
			m_axis_tdata <= {1'b0, bitmap_q, res_side_q, res_level_q, held_q};
			m_axis_tuser <= res_lout_q;
		end
	end

	lsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign cfg_ready     = 1'b1;

	`LSP_ASSERT_IMP(a_div_start_ctx, div_req.start, st_q == ST_UPD || st_q == ST_CHK, "stray start")
	`LSP_ASSERT_IMP(a_div_done_ctx, div_rsp.done, st_q == ST_NDIV || st_q == ST_CDIV, "stray done")
	`LSP_ASSERT_NXT(a_out_load, !m_valid_q && st_q != ST_OUT, !m_valid_q, "report without load")
	`LSP_ASSERT_IMP(a_lout_center, m_valid_q && m_axis_tuser, m_axis_tdata[30:25] == 6'd0, "offset")

endmodule

>>> rtl/core/lsp_div.sv
// ----------------------------------------------------------------------------
// lsp_div
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// level normalization and the centroid.
// ----------------------------------------------------------------------------
module lsp_div import lsp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  lsp_div_req_t req,
	output lsp_div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIV_W-1:0]  qd_q;
	logic [DIVS_W+1:0] trial;
	logic              ge;

	// Trial subtract of the divisor from the shifted remainder
	assign trial = {1'b0, rem_q, qd_q[DIV_W-1]} - {2'b00, dvs_q};
	assign ge    = ~trial[DIVS_W+1];

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath: shift dividend bits out, quotient bits in
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			qd_q  <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DIVS_W-1:0] : {rem_q[DIVS_W-2:0], qd_q[DIV_W-1]};
			qd_q  <= {qd_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = qd_q;

endmodule

>>> tb/tb_line_sensor_position_estimator_top.sv
// ----------------------------------------------------------------------------
// tb_line_sensor_position_estimator_top
// Self-checking bench: calibrate and sample beats drive the tracker, a model
// of levels, bitmap and centroid window predicts every position report.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_line_sensor_position_estimator_top import lsp_pkg::*; ();

	localparam int NSENS      = 16;
	localparam int MINRANGE   = 1024;
	localparam int WD_LIMIT   = 20000;
	localparam int DRAIN_CYC  = 100;
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_CAL    = 1'b1;

	typedef struct packed {
		logic        action;
		logic [3:0]  idx;
		logic [11:0] x;
		logic [11:0] cmin;
		logic [11:0] cmax;
		logic        eos;
	} scan_item_t;

	typedef struct packed {
		logic [24:0] pos;
		logic [3:0]  level;
		logic [1:0]  side;
		logic        lout;
		logic [15:0] bitmap;
	} report_t;

	localparam int WEIGHTS [16] = '{12000, 10400, 8800, 7200, 5550, 3950, 2350, 750,
		-750, -2350, -3950, -5550, -7200, -8800, -10400, -12000};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;

	scan_item_t scan_items[$];
	report_t    expected_reports[$];
	scan_item_t item_on_bus;
	int send_idle = 0;
	int recv_idle = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	// tracker model state
	logic [6:0]  thr_m = THR_RESET;
	logic [6:0]  level_m [16];
	logic [11:0] min_m [16];
	logic [12:0] range_m [16];
	logic [15:0] bitmap_m = '0;
	logic [3:0]  win_m = 4'd6;
	logic [24:0] held_m = '0;

	line_sensor_position_estimator_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Scale a raw reading with the stored dark level and span
	function automatic logic [6:0] scale_level(input logic [3:0] k, input logic [11:0] x);
		longint mn, rg, q;
		mn = min_m[k];
		rg = $signed(range_m[k]);
		if (longint'(x) > mn + rg) return LEVEL_MAX;
		if (longint'(x) < mn) return 7'd0;
		if (rg < MINRANGE) return 7'd0;
		q = ((longint'(x) - mn) << 17) / rg;
		return 7'((q * 127) >> 17);
	endfunction

	// Apply one accepted beat to the model, queue a report on end of scan
	task automatic track_item(input scan_item_t it);
		longint s, d, pos, cur;
		logic [6:0] n;
		report_t r;
		logic [3:0] k;
		if (it.idx < NSENS) begin
			if (it.action == ACT_CAL) begin
				min_m[it.idx] = it.cmin;
				range_m[it.idx] = 13'(it.cmax) - 13'(it.cmin);
			end else begin
				n = scale_level(it.idx, it.x);
				level_m[it.idx] = n;
				bitmap_m[it.idx] = (n > thr_m);
			end
		end
		if (!it.eos) return;
		s = 0;
		d = 0;
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			k = win_m + 4'(i);
			s += longint'(WEIGHTS[k]) * longint'(level_m[k]);
			d += longint'(level_m[k]);
		end
		r = '0;
		if (d == 0) begin
			r.lout = 1'b1;
		end else begin
			pos = ((s * 256) / d) * 4;
			if (pos > 12288000) pos = 12288000;
			else if (pos < -12288000) pos = -12288000;
			held_m = 25'(pos);
			cur = (pos >= 0) ? pos / 1024 : -((-pos + 1023) / 1024);
			win_m = WIN_CENTER;
			for (int i = 0; i < 8; i++) begin
				if (cur > WEIGHTS[i]) begin
					r.level = 4'(8 - i);
					r.side = SIDE_RIGHT;
					win_m = (r.level >= 6) ? 4'd0 : 4'd6 - r.level;
					break;
				end
				if (cur < WEIGHTS[15 - i]) begin
					r.level = 4'(8 - i);
					r.side = SIDE_LEFT;
					win_m = (r.level >= 6) ? WIN_LAST : 4'd6 + r.level;
					break;
				end
			end
		end
		r.pos = held_m;
		r.bitmap = bitmap_m;
		expected_reports.push_back(r);
	endtask

	// Driver: advance to the next pending beat, or idle at random
	always @(posedge clk) begin
		logic next_valid;
		if (arst_n) begin
			next_valid = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				track_item(item_on_bus);
				next_valid = 1'b0;
			end
			if (!next_valid && scan_items.size() > 0 && $urandom_range(99) >= send_idle) begin
				item_on_bus = scan_items.pop_front();
				s_axis_tdata <= {item_on_bus.cmax, item_on_bus.cmin, item_on_bus.x,
					item_on_bus.idx};
				s_axis_tuser <= item_on_bus.action;
				s_axis_tlast <= item_on_bus.eos;
				next_valid = 1'b1;
			end
			s_axis_tvalid <= next_valid;
		end
	end

	// Monitor: check each report beat against the oldest prediction
	always @(posedge clk) begin
		report_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[24:0], m_axis_tdata[28:25], m_axis_tdata[30:29],
					m_axis_tuser, m_axis_tdata[46:31]};
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected report %h", got);
				end else begin
					want = expected_reports.pop_front();
					if (got.pos !== want.pos || got.level !== want.level ||
							got.side !== want.side || got.lout !== want.lout ||
							got.bitmap !== want.bitmap) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("report mismatch: exp pos %0d lvl %0d side %0d out %0d map %h",
								$signed(want.pos), want.level, want.side, want.lout,
								want.bitmap);
							$display("                 got pos %0d lvl %0d side %0d out %0d map %h",
								$signed(got.pos), got.level, got.side, got.lout, got.bitmap);
						end
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic add_item(input logic act, input logic [3:0] k, input logic [11:0] x,
			input logic [11:0] lo, input logic [11:0] hi, input logic eos);
		scan_item_t it;
		it = '{act, k, x, lo, hi, eos};
		scan_items.push_back(it);
	endtask

	task automatic write_threshold(input logic [6:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		thr_m = v;
	endtask

	task automatic wait_idle();
		while (scan_items.size() > 0 || s_axis_tvalid || expected_reports.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// Mostly well-formed scans: optional calibrations, samples, end of scan
	task automatic add_random_scans(input int count);
		int n;
		logic [11:0] lo;
		for (int c = 0; c < count; c++) begin
			n = $urandom_range(6, 2);
			for (int j = 0; j < n; j++) begin
				case ($urandom_range(9))
					0: begin
						lo = 12'($urandom_range(2500));
						add_item(ACT_CAL, 4'($urandom), 12'($urandom), lo,
							12'($urandom_range(4095, lo + 1024)), j == n - 1);
					end
					1: add_item(1'($urandom), 4'($urandom), 12'($urandom), 12'($urandom),
						12'($urandom), 1'($urandom));
					default: add_item(ACT_SAMPLE, 4'($urandom), 12'($urandom),
						12'($urandom), 12'($urandom), j == n - 1);
				endcase
			end
		end
	endtask

	initial begin
		int idle_set [4][2];
		logic [6:0] thr_set [4];
		for (int i = 0; i < 16; i++) begin
			level_m[i] = '0;
			min_m[i] = '0;
			range_m[i] = '0;
		end
		idle_set = '{'{0, 0}, '{73, 0}, '{0, 73}, '{30, 30}};
		thr_set = '{7'd0, 7'd127, 7'd64, 7'd0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: line out after reset, invalid spans, extremes, far sensor
		add_item(ACT_SAMPLE, 4'd6, 12'd2000, 12'd0, 12'd0, 1'b1);
		add_item(ACT_SAMPLE, 4'd7, 12'd4095, 12'd0, 12'd0, 1'b1);
		add_item(ACT_CAL, 4'd6, 12'd0, 12'd0, 12'd4095, 1'b0);
		add_item(ACT_CAL, 4'd7, 12'd0, 12'd1000, 12'd2024, 1'b0);
		add_item(ACT_CAL, 4'd8, 12'd0, 12'd1000, 12'd2023, 1'b0);
		add_item(ACT_CAL, 4'd9, 12'd0, 12'd3000, 12'd100, 1'b0);
		add_item(ACT_CAL, 4'd5, 12'd0, 12'd500, 12'd500, 1'b0);
		add_item(ACT_SAMPLE, 4'd6, 12'd4095, 12'd0, 12'd0, 1'b0);
		add_item(ACT_SAMPLE, 4'd7, 12'd1500, 12'd0, 12'd0, 1'b0);
		add_item(ACT_SAMPLE, 4'd8, 12'd1500, 12'd0, 12'd0, 1'b0);
		add_item(ACT_SAMPLE, 4'd9, 12'd2000, 12'd0, 12'd0, 1'b1);
		add_item(ACT_SAMPLE, 4'd7, 12'd0, 12'd0, 12'd0, 1'b0);
		add_item(ACT_SAMPLE, 4'd8, 12'd4095, 12'd0, 12'd0, 1'b1);
		add_item(ACT_SAMPLE, 4'd5, 12'd500, 12'd0, 12'd0, 1'b0);
		add_item(ACT_SAMPLE, 4'd6, 12'd0, 12'd0, 12'd0, 1'b1);
		add_item(ACT_CAL, 4'd0, 12'd0, 12'd0, 12'd4095, 1'b0);
		add_item(ACT_SAMPLE, 4'd0, 12'd4095, 12'd0, 12'd0, 1'b1);
		add_item(ACT_CAL, 4'd15, 12'd0, 12'd4095, 12'd4095, 1'b0);
		add_item(ACT_SAMPLE, 4'd15, 12'd4095, 12'd0, 12'd0, 1'b1);
		add_item(ACT_CAL, 4'd12, 12'd0, 12'd0, 12'd4095, 1'b1);
		add_item(ACT_SAMPLE, 4'd12, 12'd4095, 12'd0, 12'd0, 1'b1);
		wait_idle();
		for (int p = 0; p < 4; p++) begin
			write_threshold((p == 3) ? 7'($urandom) : thr_set[p]);
			send_idle = idle_set[p][0];
			recv_idle = idle_set[p][1];
			add_random_scans(50);
			wait_idle();
		end
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lsp_pkg.sv
rtl/core/lsp_div.sv
rtl/core/line_sensor_position_estimator_top.sv
tb/tb_line_sensor_position_estimator_top.sv
